@@ rtl/phh_pkg.sv @@
// ----------------------------------------------------------------------------
// PC hotspot histogram package
// Shared widths, codes, request and response types for the hash histogram.
// ----------------------------------------------------------------------------
package phh_pkg;

  localparam int PC_W     = 48;
  localparam int CNT_W    = 32;
  localparam int TSEL_W   = 4;
  localparam int RB_W     = 5;
  localparam int HASH_SHIFT = 13;

  localparam int BUCKETS_DEF = 32;
  localparam int TABLES_DEF  = 12;
  localparam int PROBES_DEF  = 4;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_COUNTED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  typedef struct packed {
    logic              func;
    logic [TSEL_W-1:0] table_sel;
    logic [PC_W-1:0]   pc;
    logic [RB_W-1:0]   read_bucket;
  } in_req_t;

  typedef struct packed {
    status_t          status;
    logic [RB_W-1:0]  bucket_used;
    logic [PC_W-1:0]  entry_pc;
    logic [CNT_W-1:0] entry_count;
  } out_rsp_t;

  typedef struct packed {
    logic [PC_W-1:0]  pc;
    logic [CNT_W-1:0] cnt;
  } entry_t;

endpackage

@@ rtl/phh_table_ram.sv @@
// ----------------------------------------------------------------------------
// PC hotspot histogram bucket memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module phh_table_ram
  import phh_pkg::*;
#(
  parameter int AW    = 9,
  parameter int DEPTH = 384
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/pc_hotspot_hash_histogram_unit.sv @@
// ----------------------------------------------------------------------------
// PC hotspot hash histogram
// Per-table linear-probing hash counter of sampled program counters.
// ----------------------------------------------------------------------------
// Usage: a request on in_data (valid/stall) either records a PC sample in
// the table chosen by table_sel or reads one bucket back. Every request
// produces exactly one response on out_data (valid/stall), in order.
// A record hashes pc ^ (pc >> 13) to a home bucket and probes up to PROBES
// consecutive buckets through one read port and one compare/increment unit,
// one probe per cycle. A record passes through S_RD, then one S_CHK per probed
// bucket, then S_EMIT, which loads the output register; a bucket read passes
// through S_RD, S_CHK and S_EMIT, and an ignored record, or a read of a table
// at or above TABLES, goes straight to S_EMIT. The block takes the next request
// only once S_EMIT has returned to S_IDLE.
// After reset the block sweeps all TABLES * BUCKETS entries (384 by default) of
// the bucket memory to zero, one entry per cycle; in_stall stays high
// meanwhile. A finished response waits in the output register while the
// receiver stalls; the block can accept one more request meanwhile but
// holds its result until the output register is free.
// ----------------------------------------------------------------------------
module pc_hotspot_hash_histogram_unit
  import phh_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int TABLES  = TABLES_DEF,
  parameter int PROBES  = PROBES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_data
);

  localparam int IDXW  = $clog2(BUCKETS);
  localparam int TW    = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int AW    = TW + IDXW;
  localparam int DEPTH = TABLES * BUCKETS;
  localparam int PW    = (PROBES > 1) ? $clog2(PROBES) : 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RD    = 5'b00100,
    S_CHK   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [TW-1:0]   tsel_r, tsel_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [IDXW-1:0] bkt_r, bkt_nxt;
  logic [PW-1:0]   probe_r, probe_nxt;
  logic            is_read_r, is_read_nxt;
  out_rsp_t        res_r, res_nxt;
  out_rsp_t        out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            in_fire;
  logic            slot_free;
  logic            tsel_ok;
  logic [PC_W-1:0] hash_full;
  logic [IDXW-1:0] home;
  logic [IDXW-1:0] rb;
  logic [IDXW-1:0] bkt_inc;
  logic [CNT_W-1:0] cnt_inc;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;
  logic [AW-1:0]   rd_addr;
  entry_t          rd_data;

  phh_table_ram #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign tsel_ok   = ({1'b0, in_data.table_sel} < (TSEL_W + 1)'(TABLES));
  assign hash_full = in_data.pc ^ (in_data.pc >> HASH_SHIFT);
  assign home      = hash_full[IDXW-1:0];
  assign rb        = IDXW'(in_data.read_bucket);
  assign bkt_inc   = bkt_r + IDXW'(1);
  assign cnt_inc   = (rd_data.cnt == '1) ? rd_data.cnt : rd_data.cnt + CNT_W'(1);

  // While checking one probe, the next bucket is already being read.
  assign rd_addr = (state_r == S_CHK) ? {tsel_r, bkt_inc} : {tsel_r, bkt_r};

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    tsel_nxt      = tsel_r;
    pc_nxt        = pc_r;
    bkt_nxt       = bkt_r;
    probe_nxt     = probe_r;
    is_read_nxt   = is_read_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = {tsel_r, bkt_r};
    wr_data       = '0;

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          tsel_nxt    = in_data.table_sel[TW-1:0];
          pc_nxt      = in_data.pc;
          probe_nxt   = '0;
          is_read_nxt = (in_data.func == FUNC_READ);
          res_nxt     = '0;
          res_nxt.status = ST_IGNORED;
          if (in_data.func == FUNC_READ) begin
            bkt_nxt = rb;
            res_nxt.bucket_used = RB_W'(rb);
            state_nxt = tsel_ok ? S_RD : S_EMIT;
          end else begin
            bkt_nxt   = home;
            state_nxt = (tsel_ok && (in_data.pc != '0)) ? S_RD : S_EMIT;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        res_nxt.bucket_used = RB_W'(bkt_r);
        if (is_read_r) begin
          res_nxt.status      = ST_IGNORED;
          res_nxt.entry_pc    = rd_data.pc;
          res_nxt.entry_count = rd_data.cnt;
          state_nxt           = S_EMIT;
        end else if (rd_data.pc == pc_r) begin
          wr_en               = 1'b1;
          wr_data.pc          = pc_r;
          wr_data.cnt         = cnt_inc;
          res_nxt.status      = ST_COUNTED;
          res_nxt.entry_pc    = pc_r;
          res_nxt.entry_count = cnt_inc;
          state_nxt           = S_EMIT;
        end else if (rd_data.pc == '0) begin
          wr_en               = 1'b1;
          wr_data.pc          = pc_r;
          wr_data.cnt         = CNT_W'(1);
          res_nxt.status      = ST_INSERTED;
          res_nxt.entry_pc    = pc_r;
          res_nxt.entry_count = CNT_W'(1);
          state_nxt           = S_EMIT;
        end else if (probe_r == PW'(PROBES - 1)) begin
          res_nxt        = '0;
          res_nxt.status = ST_DROPPED;
          state_nxt      = S_EMIT;
        end else begin
          probe_nxt = probe_r + PW'(1);
          bkt_nxt   = bkt_inc;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tsel_r    <= tsel_nxt;
    pc_r      <= pc_nxt;
    bkt_r     <= bkt_nxt;
    probe_r   <= probe_nxt;
    is_read_r <= is_read_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/phh_checker.sv @@
// ----------------------------------------------------------------------------
// PC hotspot histogram port checker
// Watches the request and response channels of the histogram unit.
// ----------------------------------------------------------------------------
module phh_checker
  import phh_pkg::*;
#(
  parameter int TABLES = TABLES_DEF
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input in_req_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input out_rsp_t out_data
);

  logic       in_acc;
  logic       out_acc;
  logic       rd_live;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // A bucket read of an existing table goes through the memory.
  assign rd_live = in_acc && (in_data.func == FUNC_READ) &&
                   ({1'b0, in_data.table_sel} < (TSEL_W + 1)'(TABLES));

  // Requests accepted but whose responses have not been taken yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("response changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("response without a pending request");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two requests outstanding");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd2 |-> in_stall)
    else $error("request accepted with two responses pending");

  a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
    rd_live && pend_r == 2'd0 |->
      ##4 out_valid && out_data.status == ST_IGNORED)
    else $error("bucket read did not answer in time");

endmodule

bind pc_hotspot_hash_histogram_unit phh_checker #(
  .TABLES (TABLES)
) u_phh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
